/* hw/rtl/swlct_pkg.sv */
// swlct_pkg: shared types, constants and helpers for the stopwatch / countdown timer
// used by swlct_in_reg, swlct_core and stopwatch_lap_countdown_timer
// no dependencies
package swlct_pkg;

    localparam int unsigned LAP_MAX = 9999;

    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_SW_START  = 3'd1,
        MODE_SW_PAUSE  = 3'd2,
        MODE_LAP       = 3'd3,
        MODE_SW_RESET  = 3'd4,
        MODE_CD_START  = 3'd5,
        MODE_CD_PAUSE  = 3'd6,
        MODE_CD_CANCEL = 3'd7
    } t_mode;

    // time held as separate binary fields, hh wide enough for the countdown range
    typedef struct packed {
        logic [6:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
        logic [6:0] cc;
    } t_time;

    typedef struct packed {
        t_mode      mode;
        logic [6:0] preset_hours;
        logic [5:0] preset_minutes;
        logic [5:0] preset_seconds;
        logic [6:0] preset_centis;
    } t_in_item;

    typedef struct packed {
        logic [31:0] stopwatch_bcd;
        logic [31:0] countdown_bcd;
        logic [13:0] lap_number;
        logic [31:0] split_bcd;
        logic        split_valid;
        logic        alarm_pulse;
        logic        alarm_sounding;
        logic        stopwatch_running;
        logic        countdown_running;
    } t_result;

    // two bcd digits of a value below 100; tens by reciprocal multiply (205 / 2048)
    function automatic logic [7:0] bin2bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

    function automatic logic [31:0] time2bcd(input t_time t);
        return {bin2bcd(t.hh), bin2bcd({1'b0, t.mm}), bin2bcd({1'b0, t.ss}), bin2bcd(t.cc)};
    endfunction

endpackage

/* hw/rtl/swlct_in_reg.sv */
// swlct_in_reg: input register stage of the timer
// depends on swlct_pkg
module swlct_in_reg
    import swlct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_ready,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_vld;
    t_in_item r_item;

    assign o_ready = !r_vld || i_advance;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

/* hw/rtl/swlct_core.sv */
// swlct_core: timer state and the per-word update, result formed from the next state, split from the current state
// depends on swlct_pkg
module swlct_core
    import swlct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output t_result  o_result
);

    t_time       r_sw, n_sw;
    t_time       r_cd, n_cd;
    t_time       r_prev, n_prev;
    logic [13:0] r_laps, n_laps;
    logic        r_sw_act, n_sw_act;
    logic        r_cd_act, n_cd_act;
    logic        r_alarm, n_alarm;

    t_time sw_inc, cd_dec, split, preset;
    logic  pulse;
    logic  cd_zero, preset_zero;

    // split = sw - prev modulo one day, borrow rippled field to field
    logic [7:0] d_cc, d_hh;
    logic [6:0] d_ss, d_mm;
    logic       b_cc, b_ss, b_mm;

    always_comb begin
        d_cc = {1'b0, r_sw.cc} - {1'b0, r_prev.cc};
        b_cc = d_cc[7];
        split.cc = b_cc ? 7'(d_cc + 8'd100) : d_cc[6:0];
        d_ss = {1'b0, r_sw.ss} - {1'b0, r_prev.ss} - {6'd0, b_cc};
        b_ss = d_ss[6];
        split.ss = b_ss ? 6'(d_ss + 7'd60) : d_ss[5:0];
        d_mm = {1'b0, r_sw.mm} - {1'b0, r_prev.mm} - {6'd0, b_ss};
        b_mm = d_mm[6];
        split.mm = b_mm ? 6'(d_mm + 7'd60) : d_mm[5:0];
        d_hh = {1'b0, r_sw.hh} - {1'b0, r_prev.hh} - {7'd0, b_mm};
        split.hh = d_hh[7] ? 7'(d_hh + 8'd24) : d_hh[6:0];
    end

    // stopwatch increment; reaching 24 h clears the stopwatch time and stops it
    always_comb begin
        sw_inc = r_sw;
        if (r_sw.cc != 7'd99) begin
            sw_inc.cc = r_sw.cc + 7'd1;
        end else begin
            sw_inc.cc = '0;
            if (r_sw.ss != 6'd59) begin
                sw_inc.ss = r_sw.ss + 6'd1;
            end else begin
                sw_inc.ss = '0;
                if (r_sw.mm != 6'd59) begin
                    sw_inc.mm = r_sw.mm + 6'd1;
                end else begin
                    sw_inc.mm = '0;
                    sw_inc.hh = r_sw.hh + 7'd1;
                end
            end
        end
    end

    // countdown decrement, only used when nonzero
    always_comb begin
        cd_dec = r_cd;
        if (r_cd.cc != 7'd0) begin
            cd_dec.cc = r_cd.cc - 7'd1;
        end else begin
            cd_dec.cc = 7'd99;
            if (r_cd.ss != 6'd0) begin
                cd_dec.ss = r_cd.ss - 6'd1;
            end else begin
                cd_dec.ss = 6'd59;
                if (r_cd.mm != 6'd0) begin
                    cd_dec.mm = r_cd.mm - 6'd1;
                end else begin
                    cd_dec.mm = 6'd59;
                    cd_dec.hh = r_cd.hh - 7'd1;
                end
            end
        end
    end

    always_comb begin
        preset.hh = (i_item.preset_hours > 7'd99) ? 7'd99 : i_item.preset_hours;
        preset.mm = (i_item.preset_minutes > 6'd59) ? 6'd59 : i_item.preset_minutes;
        preset.ss = (i_item.preset_seconds > 6'd59) ? 6'd59 : i_item.preset_seconds;
        preset.cc = (i_item.preset_centis > 7'd99) ? 7'd99 : i_item.preset_centis;
    end

    assign cd_zero     = (r_cd == '0);
    assign preset_zero = (preset == '0);

    always_comb begin
        n_sw     = r_sw;
        n_cd     = r_cd;
        n_prev   = r_prev;
        n_laps   = r_laps;
        n_sw_act = r_sw_act;
        n_cd_act = r_cd_act;
        n_alarm  = r_alarm;
        pulse    = 1'b0;
        unique case (i_item.mode)
            MODE_TICK: begin
                if (r_sw_act) begin
                    if (sw_inc.hh == 7'd24) begin
                        n_sw     = '0;
                        n_sw_act = 1'b0;
                    end else begin
                        n_sw = sw_inc;
                    end
                end
                if (r_cd_act) begin
                    if (!cd_zero) begin
                        n_cd = cd_dec;
                    end
                    if (cd_zero || cd_dec == '0) begin
                        pulse    = 1'b1;
                        n_alarm  = 1'b1;
                        n_cd_act = 1'b0;
                    end
                end
            end
            MODE_SW_START: begin
                n_sw_act = 1'b1;
            end
            MODE_SW_PAUSE: begin
                n_sw_act = 1'b0;
            end
            MODE_LAP: begin
                if (r_laps < 14'(LAP_MAX)) begin
                    n_laps = r_laps + 14'd1;
                end
                n_prev = r_sw;
            end
            MODE_SW_RESET: begin
                n_sw_act = 1'b0;
                n_sw     = '0;
                n_laps   = '0;
                n_prev   = '0;
            end
            MODE_CD_START: begin
                n_alarm = 1'b0;
                if (cd_zero) begin
                    n_cd = preset;
                end
                if (!cd_zero || !preset_zero) begin
                    n_cd_act = 1'b1;
                end
            end
            MODE_CD_PAUSE: begin
                n_cd_act = 1'b0;
                n_alarm  = 1'b0;
            end
            MODE_CD_CANCEL: begin
                n_cd_act = 1'b0;
                n_alarm  = 1'b0;
                n_cd     = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.stopwatch_bcd     = time2bcd(n_sw);
        o_result.countdown_bcd     = time2bcd(n_cd);
        o_result.lap_number        = n_laps;
        o_result.split_valid       = (i_item.mode == MODE_LAP);
        o_result.split_bcd         = o_result.split_valid ? time2bcd(split) : '0;
        o_result.alarm_pulse       = pulse;
        o_result.alarm_sounding    = n_alarm;
        o_result.stopwatch_running = n_sw_act;
        o_result.countdown_running = n_cd_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw     <= '0;
            r_cd     <= '0;
            r_prev   <= '0;
            r_laps   <= '0;
            r_sw_act <= 1'b0;
            r_cd_act <= 1'b0;
            r_alarm  <= 1'b0;
        end else if (i_fire) begin
            r_sw     <= n_sw;
            r_cd     <= n_cd;
            r_prev   <= n_prev;
            r_laps   <= n_laps;
            r_sw_act <= n_sw_act;
            r_cd_act <= n_cd_act;
            r_alarm  <= n_alarm;
        end
    end

endmodule

/* hw/rtl/stopwatch_lap_countdown_timer.sv */
// stopwatch_lap_countdown_timer: top level, input register, timer core, result register
// depends on swlct_pkg, swlct_in_reg, swlct_core
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata presets
//  m_      | out | m_tvalid/m_tready  | m_tuser split_valid, m_tdata times, laps, flags
//
// each word gives exactly one result word, which passes the input register and the result register on its way to m_
// one word per cycle sustained while m_ does not stall; the single state update per word in swlct_core sets this
// reset clears both timers, the lap count, the alarm and both pipeline stages
// a stalled m_ side holds its word; s_ keeps taking words until the input register fills
module stopwatch_lap_countdown_timer
    import swlct_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [6:0] preset_hours, [12:7] preset_minutes, [18:13] preset_seconds,
    // [25:19] preset_centis, [31:26] zero
    input  logic [31:0]  s_tdata,
    // [2:0] mode
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] stopwatch_bcd, [63:32] countdown_bcd, [77:64] lap_number,
    // [109:78] split_bcd, [110] alarm_pulse, [111] alarm_sounding,
    // [112] stopwatch_running, [113] countdown_running, [119:114] zero
    output logic [119:0] m_tdata,
    // [0] split_valid
    output logic [0:0]   m_tuser
);

    t_in_item s_item, q_item;
    logic     q_valid;
    logic     advance;
    logic     fire;
    t_result  core_res;
    t_result  r_res;
    logic     r_out_vld;

    assign s_item.mode           = t_mode'(s_tuser);
    assign s_item.preset_hours   = s_tdata[6:0];
    assign s_item.preset_minutes = s_tdata[12:7];
    assign s_item.preset_seconds = s_tdata[18:13];
    assign s_item.preset_centis  = s_tdata[25:19];

    assign advance = !r_out_vld || m_tready;
    assign fire    = q_valid && advance;

    swlct_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .i_item    (s_item),
        .i_advance (advance),
        .o_ready   (s_tready),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    swlct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (q_item),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= q_valid;
        end
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_res.split_valid;
    assign m_tdata  = {6'd0,
                       r_res.countdown_running,
                       r_res.stopwatch_running,
                       r_res.alarm_sounding,
                       r_res.alarm_pulse,
                       r_res.split_bcd,
                       r_res.lap_number,
                       r_res.countdown_bcd,
                       r_res.stopwatch_bcd};

endmodule

/* verif/tb_stopwatch_lap_countdown_timer.sv */
// tb_stopwatch_lap_countdown_timer: self-checking bench for the stopwatch / countdown timer
// holds its own timer model, drives s_ words and checks every m_ word against it
// depends on swlct_pkg and stopwatch_lap_countdown_timer
`timescale 1ns / 100ps

module tb_stopwatch_lap_countdown_timer;
    import swlct_pkg::*;

    localparam int unsigned CS_PER_HOUR    = 360000;
    localparam int unsigned CS_PER_MIN     = 6000;
    localparam int unsigned CS_PER_SEC     = 100;
    localparam int unsigned CS_PER_DAY     = 8640000;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          MAX_PRINTED    = 20;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic [0:0]   m_tuser;

    stopwatch_lap_countdown_timer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // timer model state, all times in hundredths
    int unsigned sw_cs;
    int unsigned cd_cs;
    int unsigned lap_mark_cs;
    int unsigned laps_taken;
    bit          sw_on;
    bit          cd_on;
    bit          alarm_on;

    t_result readouts_due[$];
    int      mismatch_count;
    int      src_idle_pct;
    int      sink_stall_pct;
    int      stall_cycles;

    function automatic logic [7:0] two_bcd_digits(input int unsigned v);
        return {4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    function automatic logic [31:0] cs_to_bcd(input int unsigned cs);
        return {two_bcd_digits(cs / CS_PER_HOUR),
                two_bcd_digits((cs % CS_PER_HOUR) / CS_PER_MIN),
                two_bcd_digits((cs % CS_PER_MIN) / CS_PER_SEC),
                two_bcd_digits(cs % CS_PER_SEC)};
    endfunction

    function automatic int unsigned limit_to(input int unsigned v, input int unsigned top);
        return (v > top) ? top : v;
    endfunction

    // applies one word to the model and returns the readout it should produce
    function automatic t_result step_timers(input t_mode m, input logic [6:0] h,
                                            input logic [5:0] mi, input logic [5:0] s,
                                            input logic [6:0] c);
        t_result     r;
        int unsigned split_cs;
        r        = '0;
        split_cs = 0;
        case (m)
            MODE_TICK: begin
                if (sw_on) begin
                    sw_cs++;
                    if (sw_cs >= CS_PER_DAY) begin
                        sw_on = 1'b0;
                        sw_cs = 0;
                    end
                end
                if (cd_on) begin
                    if (cd_cs != 0) cd_cs--;
                    if (cd_cs == 0) begin
                        r.alarm_pulse = 1'b1;
                        alarm_on      = 1'b1;
                        cd_on         = 1'b0;
                    end
                end
            end
            MODE_SW_START: sw_on = 1'b1;
            MODE_SW_PAUSE: sw_on = 1'b0;
            MODE_LAP: begin
                if (laps_taken < LAP_MAX) laps_taken++;
                // split wraps modulo one day when the count rolled over since the last lap
                split_cs      = (sw_cs >= lap_mark_cs) ? sw_cs - lap_mark_cs
                                                       : sw_cs + CS_PER_DAY - lap_mark_cs;
                r.split_valid = 1'b1;
                r.split_bcd   = cs_to_bcd(split_cs);
                lap_mark_cs   = sw_cs;
            end
            MODE_SW_RESET: begin
                sw_on       = 1'b0;
                sw_cs       = 0;
                laps_taken  = 0;
                lap_mark_cs = 0;
            end
            MODE_CD_START: begin
                alarm_on = 1'b0;
                if (cd_cs == 0)
                    cd_cs = limit_to(h, 99) * CS_PER_HOUR + limit_to(mi, 59) * CS_PER_MIN
                          + limit_to(s, 59) * CS_PER_SEC + limit_to(c, 99);
                if (cd_cs != 0) cd_on = 1'b1;
            end
            MODE_CD_PAUSE: begin
                cd_on    = 1'b0;
                alarm_on = 1'b0;
            end
            MODE_CD_CANCEL: begin
                cd_on    = 1'b0;
                alarm_on = 1'b0;
                cd_cs    = 0;
            end
            default: ;
        endcase
        r.stopwatch_bcd     = cs_to_bcd(sw_cs);
        r.countdown_bcd     = cs_to_bcd(cd_cs);
        r.lap_number        = 14'(laps_taken);
        r.alarm_sounding    = alarm_on;
        r.stopwatch_running = sw_on;
        r.countdown_running = cd_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // one word in, prediction queued once the block takes it
    task automatic send_word(input t_mode m, input logic [6:0] h, input logic [5:0] mi,
                             input logic [5:0] s, input logic [6:0] c);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {6'b0, c, s, mi, h};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        readouts_due.push_back(step_timers(m, h, mi, s, c));
    endtask

    task automatic press(input t_mode m);
        send_word(m, 7'd0, 6'd0, 6'd0, 7'd0);
    endtask

    task automatic ticks(input int n);
        repeat (n) press(MODE_TICK);
    endtask

    task automatic drain_readouts;
        s_tvalid <= 1'b0;
        while (readouts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic test_stopwatch_and_laps;
        press(MODE_LAP);
        press(MODE_SW_START);
        ticks(5);
        press(MODE_LAP);
        ticks(3);
        press(MODE_SW_PAUSE);
        press(MODE_TICK);
        press(MODE_LAP);
        press(MODE_SW_START);
        press(MODE_SW_START);
        ticks(2);
        press(MODE_LAP);
        press(MODE_SW_RESET);
        press(MODE_LAP);
        press(MODE_TICK);
    endtask

    task automatic test_countdown_and_alarm;
        // zero preset on an empty count must not start
        press(MODE_CD_START);
        press(MODE_TICK);
        send_word(MODE_CD_START, 7'd0, 6'd0, 6'd0, 7'd3);
        ticks(4);
        press(MODE_CD_START);
        // pause keeps the count, the next start resumes and ignores the preset
        send_word(MODE_CD_START, 7'd0, 6'd0, 6'd1, 7'd2);
        ticks(2);
        press(MODE_CD_PAUSE);
        press(MODE_TICK);
        send_word(MODE_CD_START, 7'd5, 6'd5, 6'd5, 7'd5);
        press(MODE_TICK);
        press(MODE_CD_CANCEL);
        // presets beyond range clamp to 99:59:59.99
        send_word(MODE_CD_START, 7'd127, 6'd63, 6'd63, 7'd127);
        press(MODE_TICK);
        press(MODE_CD_CANCEL);
        send_word(MODE_CD_START, 7'd99, 6'd59, 6'd59, 7'd99);
        press(MODE_CD_PAUSE);
        press(MODE_CD_CANCEL);
        send_word(MODE_CD_START, 7'd0, 6'd0, 6'd0, 7'd1);
        press(MODE_TICK);
        press(MODE_CD_PAUSE);
        send_word(MODE_CD_START, 7'd0, 6'd0, 6'd0, 7'd1);
        press(MODE_TICK);
        press(MODE_CD_CANCEL);
        // stopwatch reset leaves the countdown alone
        send_word(MODE_CD_START, 7'd0, 6'd0, 6'd0, 7'd50);
        press(MODE_SW_RESET);
        press(MODE_TICK);
        press(MODE_CD_CANCEL);
    endtask

    task automatic test_lap_run;
        press(MODE_SW_RESET);
        press(MODE_SW_START);
        for (int i = 0; i < 100; i++) begin
            if (i % 10 == 0) press(MODE_TICK);
            press(MODE_LAP);
        end
        press(MODE_SW_RESET);
    endtask

    task automatic test_random_traffic(input int n_words);
        int    pick;
        t_mode m;
        logic [6:0] h;
        logic [5:0] mi;
        logic [5:0] s;
        logic [6:0] c;
        for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(99);
            if (pick < 50)      m = MODE_TICK;
            else if (pick < 58) m = MODE_SW_START;
            else if (pick < 62) m = MODE_SW_PAUSE;
            else if (pick < 72) m = MODE_LAP;
            else if (pick < 74) m = MODE_SW_RESET;
            else if (pick < 87) m = MODE_CD_START;
            else if (pick < 93) m = MODE_CD_PAUSE;
            else                m = MODE_CD_CANCEL;
            // mostly short presets so the alarm fires, sometimes any bit pattern
            if ($urandom_range(3) == 0) begin
                h  = 7'($urandom_range(127));
                mi = 6'($urandom_range(63));
                s  = 6'($urandom_range(63));
                c  = 7'($urandom_range(127));
            end else begin
                h  = 7'd0;
                mi = 6'd0;
                s  = 6'($urandom_range(1));
                c  = 7'($urandom_range(99));
            end
            send_word(m, h, mi, s, c);
        end
    endtask

    always @(posedge i_clk)
        m_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);

    // compare each taken m_ word with the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.stopwatch_bcd     = m_tdata[31:0];
            got.countdown_bcd     = m_tdata[63:32];
            got.lap_number        = m_tdata[77:64];
            got.split_bcd         = m_tdata[109:78];
            got.alarm_pulse       = m_tdata[110];
            got.alarm_sounding    = m_tdata[111];
            got.stopwatch_running = m_tdata[112];
            got.countdown_running = m_tdata[113];
            got.split_valid       = m_tuser[0];
            if (readouts_due.size() == 0) begin
                report_mismatch("unexpected word", 32'(got.stopwatch_bcd), 32'd0);
            end else begin
                want = readouts_due.pop_front();
                if (got.stopwatch_bcd !== want.stopwatch_bcd)
                    report_mismatch("stopwatch_bcd", got.stopwatch_bcd, want.stopwatch_bcd);
                if (got.countdown_bcd !== want.countdown_bcd)
                    report_mismatch("countdown_bcd", got.countdown_bcd, want.countdown_bcd);
                if (got.lap_number !== want.lap_number)
                    report_mismatch("lap_number", 32'(got.lap_number), 32'(want.lap_number));
                if (got.split_bcd !== want.split_bcd)
                    report_mismatch("split_bcd", got.split_bcd, want.split_bcd);
                if (got.split_valid !== want.split_valid)
                    report_mismatch("split_valid", 32'(got.split_valid), 32'(want.split_valid));
                if (got.alarm_pulse !== want.alarm_pulse)
                    report_mismatch("alarm_pulse", 32'(got.alarm_pulse), 32'(want.alarm_pulse));
                if (got.alarm_sounding !== want.alarm_sounding)
                    report_mismatch("alarm_sounding", 32'(got.alarm_sounding),
                                    32'(want.alarm_sounding));
                if (got.stopwatch_running !== want.stopwatch_running)
                    report_mismatch("stopwatch_running", 32'(got.stopwatch_running),
                                    32'(want.stopwatch_running));
                if (got.countdown_running !== want.countdown_running)
                    report_mismatch("countdown_running", 32'(got.countdown_running),
                                    32'(want.countdown_running));
            end
        end
    end

    // cycles in which neither side moves a word
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("stopwatch_lap_countdown_timer regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        sw_cs          = 0;
        cd_cs          = 0;
        lap_mark_cs    = 0;
        laps_taken     = 0;
        sw_on          = 1'b0;
        cd_on          = 1'b0;
        alarm_on       = 1'b0;
        set_idling(0, 0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_stopwatch_and_laps();
        set_idling(8, 8);
        test_countdown_and_alarm();
        set_idling(0, 0);
        test_lap_run();
        drain_readouts();

        set_idling(0, 0);
        test_random_traffic(200);
        drain_readouts();
        set_idling(77, 0);
        test_random_traffic(200);
        drain_readouts();
        set_idling(0, 77);
        test_random_traffic(200);
        drain_readouts();
        set_idling(8, 8);
        test_random_traffic(200);
        drain_readouts();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("stopwatch_lap_countdown_timer regression: pass");
        else
            $display("stopwatch_lap_countdown_timer regression: fail");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/swlct_pkg.sv
hw/rtl/swlct_in_reg.sv
hw/rtl/swlct_core.sv
hw/rtl/stopwatch_lap_countdown_timer.sv
verif/tb_stopwatch_lap_countdown_timer.sv
